// File: design/ssort_pkg.sv
// ============================================================================
// ssort_pkg: shared types and constants of the selection sort engine
// Holds the set depth, the derived index widths, the word formats of both
// channels and the command and hand-off formats used between the submodules.
// ============================================================================
package ssort_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     sorted_last;
   } rsp_word_type;

   // One write and one read request to the element memory per cycle.
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_cmd_type;

   // Sorted word offered by the sequencer to the output register.
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } emit_type;

endpackage

// File: design/ssort_ram.sv
// ============================================================================
// ssort_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered and holds
// its value in cycles without a read.
// ============================================================================
module ssort_ram #(
   parameter int WIDTH  = 32,
   parameter int WORDS  = 64,
   parameter int ADDR_W = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ssort_seq.sv
// ============================================================================
// ssort_seq: load, sort and readout sequencer
// Writes arriving words into the element memory, runs the selection sort
// passes through the memory's read port, and reads the sorted set back out.
// ============================================================================
module ssort_seq
   import ssort_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  req_word_type      req_word,
   output logic              req_stall,
   output ram_cmd_type       ram_cmd,
   input  logic [DATA_W-1:0] ram_rd_data,
   output emit_type          emit,
   input  logic              emit_ready
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_OUTER,
      S_FIRST,
      S_SCAN,
      S_SWAP_A,
      S_SWAP_B,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         outer_ff, outer_in;
   logic [IDX_W-1:0]         cmp_ff, cmp_in;
   logic [IDX_W-1:0]         min_pos_ff, min_pos_in;
   logic [IDX_W-1:0]         emit_pos_ff, emit_pos_in;
   logic signed [DATA_W-1:0] min_val_ff, min_val_in;
   logic signed [DATA_W-1:0] outer_val_ff, outer_val_in;

   logic signed [DATA_W-1:0] rd_val;
   logic [CNT_W-1:0]         count_m1;
   logic [IDX_W-1:0]         last_idx;
   logic                     outer_more;
   logic                     is_less;

   assign rd_val     = $signed(ram_rd_data);
   assign count_m1   = count_ff - CNT_W'(1);
   assign last_idx   = count_m1[IDX_W-1:0];
   assign outer_more = (CNT_W'(outer_ff) + CNT_W'(1)) < count_ff;
   assign is_less    = rd_val < min_val_ff;
   assign req_stall  = (state_ff != S_LOAD);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      outer_in     = outer_ff;
      cmp_in       = cmp_ff;
      min_pos_in   = min_pos_ff;
      emit_pos_in  = emit_pos_ff;
      min_val_in   = min_val_ff;
      outer_val_in = outer_val_ff;
      ram_cmd      = '0;
      emit.valid             = 1'b0;
      emit.word.sorted_value = rd_val;
      emit.word.sorted_last  = (emit_pos_ff == last_idx);

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               // Words beyond the store depth are dropped.
               if (count_ff < CNT_W'(DEPTH)) begin
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = count_ff[IDX_W-1:0];
                  ram_cmd.wr_data = req_word.value;
                  count_in        = count_ff + CNT_W'(1);
               end
               if (req_word.last) begin
                  outer_in = '0;
                  state_in = S_OUTER;
               end
            end
         end
         S_OUTER: begin
            if (outer_more) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = outer_ff;
               state_in        = S_FIRST;
            end else begin
               outer_in    = '0;
               cmp_in      = '0;
               min_pos_in  = '0;
               emit_pos_in = '0;
               state_in    = S_EMIT_RD;
            end
         end
         S_FIRST: begin
            min_val_in      = rd_val;
            outer_val_in    = rd_val;
            min_pos_in      = outer_ff;
            cmp_in          = outer_ff + IDX_W'(1);
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = outer_ff + IDX_W'(1);
            state_in        = S_SCAN;
         end
         S_SCAN: begin
            // Strict compare keeps the earliest of equal minima.
            if (is_less) begin
               min_val_in = rd_val;
               min_pos_in = cmp_ff;
            end
            if (cmp_ff == last_idx) begin
               state_in = S_SWAP_A;
            end else begin
               cmp_in          = cmp_ff + IDX_W'(1);
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = cmp_ff + IDX_W'(1);
            end
         end
         S_SWAP_A: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = min_pos_ff;
            ram_cmd.wr_data = outer_val_ff;
            state_in        = S_SWAP_B;
         end
         S_SWAP_B: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = outer_ff;
            ram_cmd.wr_data = min_val_ff;
            outer_in        = outer_ff + IDX_W'(1);
            state_in        = S_OUTER;
         end
         S_EMIT_RD: begin
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = emit_pos_ff;
            state_in        = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            emit.valid = 1'b1;
            if (emit_ready) begin
               if (emit_pos_ff == last_idx) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  emit_pos_in = emit_pos_ff + IDX_W'(1);
                  state_in    = S_EMIT_RD;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         count_ff    <= '0;
         outer_ff    <= '0;
         cmp_ff      <= '0;
         min_pos_ff  <= '0;
         emit_pos_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         outer_ff    <= outer_in;
         cmp_ff      <= cmp_in;
         min_pos_ff  <= min_pos_in;
         emit_pos_ff <= emit_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      min_val_ff   <= min_val_in;
      outer_val_ff <= outer_val_in;
   end

endmodule

// File: design/ssort_out.sv
// ============================================================================
// ssort_out: result output register
// Holds one sorted word for the receiver and frees itself when the word is
// taken, so a new word can be loaded in the same cycle.
// ============================================================================
module ssort_out
   import ssort_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  emit_type     emit,
   output logic         emit_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         valid_ff;
   rsp_word_type word_ff;

   assign emit_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit_ready) begin
         valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid && emit_ready) begin
         word_ff <= emit.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: design/selection_sort_engine.sv
// ============================================================================
// selection_sort_engine: ascending sort of a set of signed 32-bit words
// The req channel delivers one word per element; the word with last set
// closes the set. Up to DEPTH elements are kept, further ones are dropped.
// Once the set is closed the block stalls req, sorts the stored elements in
// place by selection sort and returns them on the rsp channel in ascending
// order, with sorted_last on the greatest one. Of equal values, each pass
// picks as the minimum the one at the lowest memory position.
// Loading accepts one word per cycle. For each position the sort reads the
// position's own word, compares every remaining element through the single
// memory read port, and then writes the two words of the swap. Readout reads
// each word from the memory, then loads it into the output register, and
// starts on the next word only after that load.
// While rsp is stalled the output register holds its word and readout
// pauses; req stays stalled until the last sorted word has been loaded,
// after which a new set may start arriving even while that word waits.
// Reset is synchronous: the set is emptied, the sequencer returns to loading
// and rsp_valid drops. The element memory is not cleared.
// ============================================================================
module selection_sort_engine
   import ssort_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   ram_cmd_type       ram_cmd;
   logic [DATA_W-1:0] ram_rd_data;
   emit_type          emit;
   logic              emit_ready;

   // The sequencer owns all control: it writes incoming words, runs the
   // compare passes and the swaps, and feeds the readout.
   ssort_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_word    (req_word),
      .req_stall   (req_stall),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data),
      .emit        (emit),
      .emit_ready  (emit_ready)
   );

   // Element store: one write and one registered read per cycle.
   ssort_ram #(
      .WIDTH  (DATA_W),
      .WORDS  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register separates the receiver's stall from the sequencer.
   ssort_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .emit_ready (emit_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

// File: design/ssort_checker.sv
// ============================================================================
// ssort_checker: port-level checks of the selection sort engine
// Watches both channels and checks reset behavior, the holding of a stalled
// result word, result ordering in a set and the busy period after its close.
// ============================================================================
module ssort_checker
   import ssort_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   logic                     prev_valid_ff;
   logic signed [DATA_W-1:0] prev_value_ff;
   logic                     rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Remembers the previous result word of the current set.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         prev_valid_ff <= !rsp_word.sorted_last;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         prev_value_ff <= rsp_word.sorted_value;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && prev_valid_ff) |-> (rsp_word.sorted_value >= prev_value_ff))
      else $error("result words of a set are not ascending");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.last) |=> req_stall)
      else $error("request accepted while a set is being sorted");

endmodule

bind selection_sort_engine ssort_checker u_checker (.*);
